>>> rtl/core/pss_pkg.sv
// Shared types, sizes and codes for the positional sequence store.
// No dependencies; imported by every module of the store.
package pss_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int IN_W     = 32;
    localparam int POS_W    = 7;
    localparam int RES_W    = 39;
    localparam int OP_W     = 3;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_SUM    = 3'd4;
    localparam logic [OP_W-1:0] OP_MAX    = 3'd5;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        C_HOLD  = 2'd0,
        C_LEFT  = 2'd1,
        C_RIGHT = 2'd2,
        C_LOAD  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_val            key;
        t_cnt            l1;
        t_cnt            l2;
        t_cnt            lo;
        t_cnt            hi;
        t_cnt            cnt;
        logic            ok;
    } t_scan_cmd;

    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic [POS_W-1:0]        position;
        t_status                 status;
    } t_result;

endpackage

>>> rtl/core/pss_cell.sv
// One storage cell of the chain: holds one entry and takes a neighbor's word or the load word.
// Depends on pss_pkg.
module pss_cell import pss_pkg::*; (
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_val     i_left,
    input  t_val     i_right,
    input  t_val     i_load,
    output t_val     o_data
);

    t_val r_data;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            C_HOLD:  r_data <= r_data;
            C_LEFT:  r_data <= i_left;
            C_RIGHT: r_data <= i_right;
            C_LOAD:  r_data <= i_load;
            default: r_data <= r_data;
        endcase
    end

    assign o_data = r_data;

endmodule

>>> rtl/core/pss_scan.sv
// Query unit at the head of the cell chain: folds one entry per cycle into
// the sum, max, read or find result. Depends on pss_pkg.
module pss_scan import pss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_start,
    input  logic      i_step,
    input  t_cnt      i_k,
    input  t_val      i_head,
    input  t_scan_cmd i_cmd,
    output t_result   o_res
);

    logic signed [RES_W-1:0] r_acc;
    t_val                    r_best;
    logic                    r_found;
    logic [POS_W-1:0]        r_pos;
    logic signed [RES_W-1:0] head_x;
    logic signed [RES_W-1:0] add_x;
    logic signed [RES_W-1:0] sub_x;

    assign head_x = RES_W'(i_head);
    assign add_x  = (i_k < i_cmd.l2) ? head_x : '0;
    assign sub_x  = (i_k < i_cmd.l1) ? head_x : '0;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_best  <= '0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_step) begin
            case (i_cmd.op)
                OP_SUM: r_acc <= r_acc + add_x - sub_x;
                OP_READ: begin
                    if (i_k == i_cmd.lo) r_best <= i_head;
                end
                OP_MAX: begin
                    if (i_k == i_cmd.lo ||
                        (i_k > i_cmd.lo && i_k <= i_cmd.hi && i_head > r_best)) begin
                        r_best <= i_head;
                    end
                end
                OP_FIND: begin
                    if (!r_found && i_k < i_cmd.cnt && i_head == i_cmd.key) begin
                        r_found <= 1'b1;
                        r_pos   <= POS_W'(i_k + t_cnt'(1));
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_res.value    = '0;
        o_res.position = '0;
        o_res.status   = ST_MISS;
        case (i_cmd.op)
            OP_SUM: begin
                o_res.value  = r_acc;
                o_res.status = ST_OK;
            end
            OP_READ, OP_MAX: begin
                if (i_cmd.ok) begin
                    o_res.value  = RES_W'(r_best);
                    o_res.status = ST_OK;
                end
            end
            OP_FIND: begin
                if (r_found) begin
                    o_res.position = r_pos;
                    o_res.status   = ST_OK;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/positional_sequence_store_unit.sv
// Positional sequence store: ordered list of up to CAPACITY signed values.
// Insert, remove and unknown codes pass from S_IDLE to S_DONE, which loads the
// output register; read, find, range sum and range max pass through S_SCAN first.
// No new word is taken before the store returns to S_IDLE; queries rotate
// the chain of CAPACITY cells past the head unit, one cell per cycle.
// Reset clears count, control state and output valid and stalls the input.
module positional_sequence_store_unit import pss_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position_a,
    input  logic [POS_W-1:0]        i_position_b,
    input  logic signed [IN_W-1:0]  i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [RES_W-1:0] o_result_value,
    output logic [POS_W-1:0]        o_result_position,
    output logic [1:0]              o_status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state    r_state;
    t_cnt      r_count;
    t_cnt      r_k;
    t_scan_cmd r_cmd;
    t_result   r_res;
    logic      r_use_scan;
    logic      r_ov;
    t_result   r_out;

    t_val      cell_data [CAPACITY];
    t_cell_op  cell_op   [CAPACITY];

    logic              in_acc;
    logic              out_free;
    logic [CMP_W-1:0]  pa_x;
    logic [CMP_W-1:0]  pb_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  pa_m1;
    logic [CMP_W-1:0]  clamp_a;
    t_cnt              ins_p;
    t_cnt              rem_p;
    logic              pos_ok;
    logic              max_ok;
    logic              full;
    logic              is_query;
    t_val              key;
    logic              do_ins;
    logic              do_rem;
    logic              do_rot;
    t_result           scan_res;
    t_scan_cmd         n_cmd;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;

    assign pa_x    = CMP_W'(i_position_a);
    assign pb_x    = CMP_W'(i_position_b);
    assign cnt_x   = CMP_W'(r_count);
    assign pa_m1   = pa_x - CMP_W'(1);
    assign clamp_a = (pa_x == '0) ? '0 : ((pa_m1 > cnt_x) ? cnt_x : pa_m1);
    assign ins_p   = CNT_W'(clamp_a);
    assign rem_p   = CNT_W'(pa_m1);
    assign pos_ok  = (pa_x != '0) && (pa_x <= cnt_x);
    assign max_ok  = (r_count != '0) && (pa_x <= pb_x) && (pa_x != '0) && (pb_x <= cnt_x);
    assign full    = (r_count >= CNT_W'(CAPACITY));
    assign key     = VAL_W'(i_value);

    assign is_query = (i_operation == OP_READ) || (i_operation == OP_FIND) ||
                      (i_operation == OP_SUM) || (i_operation == OP_MAX);

    assign do_ins = in_acc && (i_operation == OP_INSERT) && !full;
    assign do_rem = in_acc && (i_operation == OP_REMOVE) && pos_ok;
    assign do_rot = (r_state == S_SCAN);

    always_comb begin
        n_cmd.op  = i_operation;
        n_cmd.key = key;
        n_cmd.l1  = ins_p;
        n_cmd.l2  = CNT_W'((pb_x > cnt_x) ? cnt_x : pb_x);
        n_cmd.lo  = rem_p;
        n_cmd.hi  = CNT_W'(pb_x - CMP_W'(1));
        n_cmd.cnt = r_count;
        n_cmd.ok  = (i_operation == OP_MAX) ? max_ok : pos_ok;
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        always_comb begin
            cell_op[gi] = C_HOLD;
            if (do_rot) begin
                cell_op[gi] = C_RIGHT;
            end else if (do_ins) begin
                if (CNT_W'(gi) == ins_p) begin
                    cell_op[gi] = C_LOAD;
                end else if (CNT_W'(gi) > ins_p) begin
                    cell_op[gi] = C_LEFT;
                end
            end else if (do_rem) begin
                if (CNT_W'(gi) >= rem_p) cell_op[gi] = C_RIGHT;
            end
        end

        pss_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[gi]),
            .i_left  (cell_data[(gi + CAPACITY - 1) % CAPACITY]),
            .i_right (cell_data[(gi + 1) % CAPACITY]),
            .i_load  (key),
            .o_data  (cell_data[gi])
        );
    end

    pss_scan u_scan (
        .i_clk   (i_clk),
        .i_start (in_acc),
        .i_step  (do_rot),
        .i_k     (r_k),
        .i_head  (cell_data[0]),
        .i_cmd   (r_cmd),
        .o_res   (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_k        <= '0;
            r_use_scan <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_k        <= '0;
                        r_use_scan <= is_query;
                        r_state    <= is_query ? S_SCAN : S_DONE;
                        case (i_operation)
                            OP_INSERT: begin
                                if (!full) r_count <= r_count + t_cnt'(1);
                            end
                            OP_REMOVE: begin
                                if (pos_ok) r_count <= r_count - t_cnt'(1);
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_k == CNT_W'(CAPACITY - 1)) begin
                        r_k     <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + t_cnt'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd          <= n_cmd;
            r_res.value    <= '0;
            r_res.position <= '0;
            case (i_operation)
                OP_INSERT: r_res.status <= full ? ST_FULL : ST_OK;
                OP_REMOVE: r_res.status <= pos_ok ? ST_OK : ST_MISS;
                default:   r_res.status <= ST_MISS;
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_use_scan ? scan_res : r_res;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_result_value    = r_out.value;
    assign o_result_position = r_out.position;
    assign o_status          = r_out.status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_INSERT && !full)
        |=> (r_count == $past(r_count) + t_cnt'(1)))
        else $error("insert did not grow count");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_k == '0))
        else $error("scan index not parked while idle");

    a_scan_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_count == $past(r_count)))
        else $error("count changed during scan");
`endif

endmodule
